// ----- hw/rtl/gpa_pkg.sv -----
`timescale 1ns / 1ps

package gpa_pkg;

  // Operand width of the arithmetic; the ports keep their fixed widths.
  localparam int POLY_WIDTH = 32;
  localparam int IN_W       = 32;
  localparam int MAIN_W     = 63;
  localparam int REM_W      = 32;
  localparam int ACC_W      = 2 * POLY_WIDTH - 1;
  localparam int CNT_W      = $clog2(POLY_WIDTH + 1);

  // Command codes.
  localparam logic [1:0] CMD_MUL  = 2'd0;
  localparam logic [1:0] CMD_DIV  = 2'd1;
  localparam logic [1:0] CMD_GCD  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef logic [ACC_W-1:0]      acc_t;
  typedef logic [POLY_WIDTH-1:0] poly_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IN_W-1:0]       in_t;
  typedef logic [MAIN_W-1:0]     main_t;
  typedef logic [REM_W-1:0]      rem_t;

endpackage

// ----- hw/rtl/gpa_alu.sv -----
`timescale 1ns / 1ps

// Shared conditional xor and magnitude compare, used by the multiply, divide and gcd commands.
module gpa_alu
  import gpa_pkg::*;
(
  input  acc_t x,
  input  acc_t y,
  input  logic xor_en,
  output acc_t z,
  output logic ge
);

  // Adding a polynomial over GF(2) is a plain xor.
  assign z = xor_en ? (x ^ y) : x;

  // A larger integer value never has a lower degree.
  assign ge = (x >= y);

endmodule

// ----- hw/rtl/gf2_poly_arith_unit.sv -----
`timescale 1ns / 1ps

// Arithmetic on binary polynomials over GF(2); bit i holds the coefficient of x^i.
// A command word (command, first_poly, second_poly) is taken at a rising edge
// where start is high and busy is low. Command 0 gives the carry-less product,
// command 1 the quotient and remainder, command 2 the gcd; command 3 gives zeros.
// The result word (main_result, remainder_poly, divide_error) is shown for one
// cycle with done high; the receiver cannot hold it off, so it must take it then.
// One shared xor/compare unit is stepped by a small sequencer, one step a cycle:
//   multiply: one shift-and-xor step per multiplier bit; the last step gives the product.
//   divide:   divisor alignment by shifts, then one reduction step per quotient bit.
//   gcd:      binary reduction, one shift, swap or xor a step, then one shift back
//             per common factor of x; data dependent.
//   zero divisor or unused command: result in the next cycle, busy stays low.
// busy is high while a word is being worked on; a new word may be given in the
// cycle in which done is high. Reset clears the sequencer and the done strobe.
module gf2_poly_arith_unit
  import gpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  in_t        first_poly,
  input  in_t        second_poly,
  output logic       done,
  output main_t      main_result,
  output rem_t       remainder_poly,
  output logic       divide_error
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_NORM   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_GCD    = 3'd4;
  localparam logic [2:0] ST_GSHIFT = 3'd5;

  localparam poly_t TOP_BIT = poly_t'(1) << (POLY_WIDTH - 1);

  logic [2:0] state;
  acc_t       ra;
  acc_t       rb;
  poly_t      rc;
  poly_t      tm;
  cnt_t       cnt;

  poly_t op_a;
  poly_t op_b;
  poly_t ga;
  poly_t gb;
  logic  div_bit;
  logic  alu_en;
  acc_t  alu_z;
  logic  alu_ge;

  assign op_a = first_poly[POLY_WIDTH-1:0];
  assign op_b = second_poly[POLY_WIDTH-1:0];
  assign ga   = ra[POLY_WIDTH-1:0];
  assign gb   = rb[POLY_WIDTH-1:0];
  assign busy = (state != ST_IDLE);

  // The divisor's leading term always sits under the one-hot mask tm.
  assign div_bit = |(ga & tm);

  // Select when the shared unit adds its second operand.
  always_comb begin
    case (state)
      ST_MUL:  alu_en = rc[0];
      ST_DIV:  alu_en = div_bit;
      ST_GCD:  alu_en = 1'b1;
      default: alu_en = 1'b0;
    endcase
  end

  gpa_alu u_alu (
    .x      (ra),
    .y      (rb),
    .xor_en (alu_en),
    .z      (alu_z),
    .ge     (alu_ge)
  );

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (command)
              CMD_MUL: begin
                ra    <= '0;
                rb    <= acc_t'(op_b);
                rc    <= op_a;
                cnt   <= cnt_t'(POLY_WIDTH);
                state <= ST_MUL;
              end
              CMD_DIV: begin
                if (op_b == '0) begin
                  main_result    <= '0;
                  remainder_poly <= '0;
                  divide_error   <= 1'b1;
                  done           <= 1'b1;
                end else begin
                  ra    <= acc_t'(op_a);
                  rb    <= acc_t'(op_b);
                  cnt   <= '0;
                  state <= ST_NORM;
                end
              end
              CMD_GCD: begin
                ra    <= acc_t'(op_a);
                rb    <= acc_t'(op_b);
                cnt   <= '0;
                state <= ST_GCD;
              end
              default: begin
                main_result    <= '0;
                remainder_poly <= '0;
                divide_error   <= 1'b0;
                done           <= 1'b1;
              end
            endcase
          end
        end

        // Shift-and-xor product, one multiplier bit a cycle.
        ST_MUL: begin
          ra  <= alu_z;
          rb  <= rb << 1;
          rc  <= rc >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == cnt_t'(1)) begin
            main_result    <= main_t'(alu_z);
            remainder_poly <= '0;
            divide_error   <= 1'b0;
            done           <= 1'b1;
            state          <= ST_IDLE;
          end
        end

        // Align the divisor's leading term with the top bit; cnt counts shifts.
        ST_NORM: begin
          if (rb[POLY_WIDTH-1]) begin
            tm    <= TOP_BIT;
            rc    <= '0;
            state <= ST_DIV;
          end else begin
            rb  <= rb << 1;
            cnt <= cnt + 1'b1;
          end
        end

        // One quotient bit a cycle, from the highest down to x^0.
        ST_DIV: begin
          ra  <= alu_z;
          rb  <= rb >> 1;
          tm  <= tm >> 1;
          rc  <= {rc[POLY_WIDTH-2:0], div_bit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            main_result    <= main_t'({rc[POLY_WIDTH-2:0], div_bit});
            remainder_poly <= rem_t'(alu_z[POLY_WIDTH-1:0]);
            divide_error   <= 1'b0;
            done           <= 1'b1;
            state          <= ST_IDLE;
          end
        end

        // Binary gcd: strip factors of x, and xor the smaller into the larger.
        ST_GCD: begin
          if (gb == '0) begin
            state <= ST_GSHIFT;
          end else if (ga == '0) begin
            ra <= rb;
            rb <= '0;
          end else if (!ga[0] && !gb[0]) begin
            ra  <= ra >> 1;
            rb  <= rb >> 1;
            cnt <= cnt + 1'b1;
          end else if (!ga[0]) begin
            ra <= ra >> 1;
          end else if (!gb[0]) begin
            rb <= rb >> 1;
          end else if (alu_ge) begin
            ra <= alu_z;
          end else begin
            rb <= alu_z;
          end
        end

        // Restore the common factors of x removed above.
        ST_GSHIFT: begin
          if (cnt == '0) begin
            main_result    <= main_t'(ra);
            remainder_poly <= '0;
            divide_error   <= 1'b0;
            done           <= 1'b1;
            state          <= ST_IDLE;
          end else begin
            ra  <= ra << 1;
            cnt <= cnt - 1'b1;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gpa_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks on the arithmetic unit.
module gpa_checker
  import gpa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input in_t        second_poly,
  input logic       done,
  input main_t      main_result,
  input rem_t       remainder_poly,
  input logic       divide_error
);

  // A finished word always leaves the unit free for the next one.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done shown while busy");

  // An error word carries no quotient or remainder.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && divide_error) |-> (main_result == '0 && remainder_poly == '0))
    else $error("error word with nonzero fields");

  // A zero divisor is reported in the very next cycle.
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_DIV && second_poly[POLY_WIDTH-1:0] == '0)
      |=> (done && divide_error && !busy))
    else $error("zero divisor not flagged at once");

  // The unused command answers at once with an all-zero word.
  a_unused_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_NONE)
      |=> (done && !divide_error && main_result == '0 && remainder_poly == '0))
    else $error("unused command gave a wrong word");

  // Multiply or gcd work keeps the unit busy in the following cycle.
  a_work_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_MUL || command == CMD_GCD)) |=> (busy && !done))
    else $error("multiply or gcd did not start");

endmodule

bind gf2_poly_arith_unit gpa_checker u_gpa_checker (.*);
